// ===== hw/rtl/dee_pkg.sv =====
package dee_pkg;

    // stack depth and the width of a level index
    localparam int NEST_DEPTH = 16;
    localparam int LEVEL_W    = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    // word kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TOKEN = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;
    localparam logic [1:0] ST_DEEP  = 2'd3;

    // character codes
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // one saved parenthesis level
    typedef struct packed {
        logic [31:0] sum;
        logic [31:0] prod;
    } level_entry_t;

    localparam int ENTRY_W = $bits(level_entry_t);

endpackage

// ===== hw/rtl/digit_expression_evaluator.sv =====
// Streaming evaluator for expressions of single digits, '+', '*' and
// parentheses, '*' binding tighter than '+'.
// Input channel (in_valid/in_ready, kind, ch): one word per character,
// kind 0 with the byte in ch, then one word with kind 1 to end the input.
// Output channel (out_valid/out_ready, status, bad_char, value): one word
// per end marker, holding the value or the first error seen.
// Throughput: one input word per cycle unless a result is stalled.
// Every character updates the top of the level stack in the cycle it
// is accepted; the result word is registered and shows in the cycle
// after the end marker is accepted. Saved outer levels live in a small
// RAM whose read port always fetches the level below the top, with a
// forward path for a level pushed in the previous cycle.
// Reset clears the level index, the error state and the output valid flag;
// the block then waits for the first character of an expression. After
// each end marker it returns to that same state.
// When the receiver stalls, the result stays in the output register and
// in_ready is low until it is taken; in_ready is high again in the cycle
// the result is taken.
module digit_expression_evaluator
    import dee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [7:0]         ch,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [7:0]         bad_char,
    output logic signed [31:0] value
);

    localparam logic [LEVEL_W:0] DEPTH_V = (LEVEL_W + 1)'(NEST_DEPTH);

    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               want_reg, want_next;
    logic [1:0]         err_reg, err_next;
    logic [7:0]         err_ch_reg, err_ch_next;
    logic [31:0]        sum_reg, sum_next;
    logic [31:0]        prod_reg, prod_next;

    logic               fwd_valid_reg;
    level_entry_t       fwd_data_reg;

    logic               out_valid_reg;
    logic [1:0]         status_reg, status_next;
    logic [7:0]         bad_char_reg, bad_char_next;
    logic [31:0]        value_reg, value_next;

    logic               acc;
    logic               acc_char;
    logic               acc_end;
    logic               is_digit;
    logic [3:0]         digit;
    logic               room;
    logic [31:0]        inner;
    level_entry_t       below;
    level_entry_t       ram_rdata;
    level_entry_t       push_data;
    logic               push;
    logic [LEVEL_W-1:0] raddr;

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign acc      = in_valid && in_ready;
    assign acc_char = acc && (kind == KIND_CHAR);
    assign acc_end  = acc && (kind == KIND_END);

    // character decode
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = 4'(ch - CH_ZERO);
    assign room     = ({1'b0, level_reg} + (LEVEL_W + 1)'(1)) < DEPTH_V;
    assign inner    = sum_reg + prod_reg;

    // level below the top, forwarded if pushed last cycle
    assign below     = fwd_valid_reg ? fwd_data_reg : ram_rdata;
    assign push_data = '{sum: sum_reg, prod: prod_reg};

    // stack top update for one character or an end marker
    always_comb
    begin
        level_next  = level_reg;
        want_next   = want_reg;
        err_next    = err_reg;
        err_ch_next = err_ch_reg;
        sum_next    = sum_reg;
        prod_next   = prod_reg;
        push        = 1'b0;
        if (acc_end)
        begin
            level_next  = '0;
            want_next   = 1'b1;
            err_next    = ST_OK;
            err_ch_next = '0;
            sum_next    = '0;
            prod_next   = 32'd1;
        end
        else if (acc_char && (err_reg == ST_OK))
        begin
            if (want_reg)
            begin
                priority if (is_digit)
                begin
                    prod_next = prod_reg * {28'd0, digit};
                    want_next = 1'b0;
                end
                else if (ch == CH_OPEN)
                begin
                    if (room)
                    begin
                        push       = 1'b1;
                        level_next = level_reg + LEVEL_W'(1);
                        sum_next   = '0;
                        prod_next  = 32'd1;
                    end
                    else
                    begin
                        err_next = ST_DEEP;
                    end
                end
                else
                begin
                    err_next    = ST_TOKEN;
                    err_ch_next = ch;
                end
            end
            else
            begin
                priority if (ch == CH_PLUS)
                begin
                    sum_next  = inner;
                    prod_next = 32'd1;
                    want_next = 1'b1;
                end
                else if (ch == CH_STAR)
                begin
                    want_next = 1'b1;
                end
                else if ((ch == CH_CLOSE) && (level_reg != '0))
                begin
                    level_next = level_reg - LEVEL_W'(1);
                    sum_next   = below.sum;
                    prod_next  = below.prod * inner;
                end
                else
                begin
                    err_next    = ST_TOKEN;
                    err_ch_next = ch;
                end
            end
        end
    end

    // always fetch the level below the next top
    assign raddr = level_next - LEVEL_W'(1);

    dee_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NEST_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (push),
        .waddr (level_reg),
        .wdata (push_data),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // result word for an end marker
    always_comb
    begin
        bad_char_next = '0;
        value_next    = '0;
        if (err_reg != ST_OK)
        begin
            status_next = err_reg;
            if (err_reg == ST_TOKEN)
            begin
                bad_char_next = err_ch_reg;
            end
        end
        else if (want_reg || (level_reg != '0))
        begin
            status_next = ST_END;
        end
        else
        begin
            status_next = ST_OK;
            value_next  = inner;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            want_reg      <= 1'b1;
            err_reg       <= ST_OK;
            err_ch_reg    <= '0;
            sum_reg       <= '0;
            prod_reg      <= 32'd1;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            want_reg      <= want_next;
            err_reg       <= err_next;
            err_ch_reg    <= err_ch_next;
            sum_reg       <= sum_next;
            prod_reg      <= prod_next;
            fwd_valid_reg <= push;
            if (acc_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fwd_data_reg <= push_data;
        if (acc_end)
        begin
            status_reg   <= status_next;
            bad_char_reg <= bad_char_next;
            value_reg    <= value_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign bad_char  = bad_char_reg;
    assign value     = value_reg;

    // checks
    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(acc_end))
        else $error("result word without an end marker");

    a_bad_char_only_token: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_TOKEN)) |-> (bad_char_reg == '0))
        else $error("bad_char set without a token error");

    a_push_when_clean: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (want_reg && (err_reg == ST_OK) && room))
        else $error("level pushed outside an operand slot");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        acc_end |=> ((level_reg == '0) && want_reg && (err_reg == ST_OK)))
        else $error("state not restarted after end marker");

endmodule

// ===== hw/rtl/dee_ram.sv =====
module dee_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
